FILE: rtl/stsc_pkg.sv
// stsc_pkg: shared constants and helpers for the inverse stereographic projection block.
// Holds the CORDIC arctangent table, fixed-point constants and the angle clamp function.
// No dependencies.
`timescale 1ns / 1ps

package stsc_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int ANGLE_ITER_DEF  = 16;
    localparam int TABLE_LEN       = 24;
    localparam int GUARD_BITS      = 16;

    // angle accumulator, Q2.30 rad, signed
    localparam int ZW    = 33;
    // latitude CORDIC datapath width
    localparam int LAT_W = 50;

    localparam logic [29:0] INV_GAIN_Q30    = 30'd652032874;
    localparam logic [29:0] INV_PI_Q30      = 30'd341782638;
    localparam logic [29:0] TWO_OVER_PI_Q30 = 30'd683565276;
    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic [23:0] SCALE_RESET     = 24'd27146;

    // register index within the config space
    localparam logic REG_VIEW_SCALE = 1'b0;

    function automatic logic [31:0] stsc_atan(input int idx);
        logic [31:0] v;
        begin
            case (idx)
                0:  v = 32'd843314856;
                1:  v = 32'd497837829;
                2:  v = 32'd263043836;
                3:  v = 32'd133525158;
                4:  v = 32'd67021686;
                5:  v = 32'd33543515;
                6:  v = 32'd16775850;
                7:  v = 32'd8388437;
                8:  v = 32'd4194282;
                9:  v = 32'd2097149;
                10: v = 32'd1048575;
                11: v = 32'd524287;
                12: v = 32'd262143;
                13: v = 32'd131071;
                14: v = 32'd65535;
                15: v = 32'd32767;
                16: v = 32'd16383;
                17: v = 32'd8191;
                18: v = 32'd4095;
                19: v = 32'd2047;
                20: v = 32'd1023;
                21: v = 32'd511;
                22: v = 32'd255;
                23: v = 32'd127;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

    // clamp a CORDIC angle to [0, pi/2]
    function automatic logic [30:0] stsc_clamp(input logic signed [ZW-1:0] z);
        logic [30:0] c;
        begin
            if (z[ZW-1])
                c = 31'd0;
            else if (z[ZW-2:0] > {1'b0, HALF_PI_Q30})
                c = HALF_PI_Q30;
            else
                c = z[30:0];
            return c;
        end
    endfunction

endpackage

FILE: rtl/stsc_cell.sv
// stsc_cell: one vectoring CORDIC micro-rotation with a registered output.
// Uses stsc_pkg for the arctangent table and angle width.
`timescale 1ns / 1ps

module stsc_cell
    import stsc_pkg::*;
#(
    parameter int DW  = 34,
    parameter int IDX = 0,
    parameter int SW  = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic [SW-1:0]        o_side
);

    localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(stsc_atan(IDX));

    logic signed [DW-1:0] xs, ys;
    logic signed [DW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic                 r_valid;
    logic signed [DW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [SW-1:0]        r_side;

    assign xs = i_x >>> IDX;
    assign ys = i_y >>> IDX;

    always_comb begin
        if (!i_y[DW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN_STEP;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

FILE: rtl/stereographic_to_sphere_coords.sv
// stereographic_to_sphere_coords: top level, plane point to sphere longitude/latitude.
// Uses stsc_pkg and two chains of stsc_cell (radius/longitude, then latitude).
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+----------------------------------
//  point in  | in        | start, busy (always low)   | i_plane_x, i_plane_y
//  result    | out       | o_done, one-cycle strobe   | o_longitude_norm, o_latitude_norm
//  config    | in/out    | APB psel/penable/pwrite    | view_scale at byte address 0
//
// One item per clock, every clock. An accepted point passes the input register, chain 1
// (N = min(ANGLE_ITERATIONS, 24) cells, one micro-rotation per cell), two multiply stages
// (L1, L2), chain 2 (N cells), one angle-scale stage (P3) and the output register.
// Synchronous active-low reset clears the valid bits and sets view_scale to 90 deg fov.
// The receiver cannot stall; busy is tied low.
`timescale 1ns / 1ps

module stereographic_to_sphere_coords
    import stsc_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_plane_x,
    input  logic signed [COORD_WIDTH-1:0] i_plane_y,
    output logic                          o_done,
    output logic signed [15:0]            o_longitude_norm,
    output logic signed [15:0]            o_latitude_norm,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // number of cells per chain
    localparam int NC   = (ANGLE_ITERATIONS > TABLE_LEN) ? TABLE_LEN : ANGLE_ITERATIONS;
    // radius chain width: |coord| << 16, grown by CORDIC gain and sqrt(2)
    localparam int RW   = COORD_WIDTH + 18;
    // radius truncation to Q.(24 - COORD_WIDTH), Q.8 at the default 16-bit width
    localparam int RSH  = COORD_WIDTH - 8;
    localparam int XSW  = RW - RSH;
    localparam int LAT  = 2 * NC + 5;
    // flag bits in the radius chain sideband
    localparam int F_XZ = 3;
    localparam int F_YZ = 2;
    localparam int F_XN = 1;
    localparam int F_YN = 0;

    // ---------------- configuration register ----------------
    logic [23:0] r_view_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_scale <= SCALE_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_VIEW_SCALE)) begin
            r_view_scale <= pwdata[23:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VIEW_SCALE) ? {8'd0, r_view_scale} : 32'd0;
    assign busy   = 1'b0;

    // ---------------- input stage: magnitudes, zero and sign flags ----------------
    logic [COORD_WIDTH:0] ax, ay;
    logic                 r_in_valid;
    logic signed [RW-1:0] r_in_x, r_in_y;
    logic [3:0]           r_in_flags;

    assign ax = i_plane_x[COORD_WIDTH-1] ? -((COORD_WIDTH+1)'(i_plane_x))
                                         : (COORD_WIDTH+1)'(i_plane_x);
    assign ay = i_plane_y[COORD_WIDTH-1] ? -((COORD_WIDTH+1)'(i_plane_y))
                                         : (COORD_WIDTH+1)'(i_plane_y);
    // note: -(-2^(W-1)) as W+1 bits is 2^(W-1), the correct magnitude

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_x     <= RW'(ax) <<< GUARD_BITS;
        r_in_y     <= RW'(ay) <<< GUARD_BITS;
        r_in_flags <= {(i_plane_x == '0), (i_plane_y == '0),
                       i_plane_x[COORD_WIDTH-1], i_plane_y[COORD_WIDTH-1]};
    end

    // ---------------- chain 1: angle and radius of the point ----------------
    logic                 c1_v [0:NC];
    logic signed [RW-1:0] c1_x [0:NC];
    logic signed [RW-1:0] c1_y [0:NC];
    logic signed [ZW-1:0] c1_z [0:NC];
    logic [3:0]           c1_s [0:NC];

    assign c1_v[0] = r_in_valid;
    assign c1_x[0] = r_in_x;
    assign c1_y[0] = r_in_y;
    assign c1_z[0] = '0;
    assign c1_s[0] = r_in_flags;

    for (genvar g = 0; g < NC; g++) begin : g_c1
        stsc_cell #(.DW(RW), .IDX(g), .SW(4)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c1_v[g]),
            .i_x     (c1_x[g]),
            .i_y     (c1_y[g]),
            .i_z     (c1_z[g]),
            .i_side  (c1_s[g]),
            .o_valid (c1_v[g+1]),
            .o_x     (c1_x[g+1]),
            .o_y     (c1_y[g+1]),
            .o_z     (c1_z[g+1]),
            .o_side  (c1_s[g+1])
        );
    end

    // ---------------- L1: gain removal and longitude scale products ----------------
    logic [XSW-1:0] xs_rad;
    logic [55:0]    r_p_gain;
    logic [60:0]    r_p_lon;
    logic [3:0]     r_l1_flags;
    logic           r_l1_valid;

    assign xs_rad = c1_x[NC][RW-1:RSH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_valid <= 1'b0;
        end else begin
            r_l1_valid <= c1_v[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_gain   <= 56'(xs_rad) * 56'(INV_GAIN_Q30);
        r_p_lon    <= 61'(stsc_clamp(c1_z[NC])) * 61'(INV_PI_Q30);
        r_l1_flags <= c1_s[NC];
    end

    // ---------------- L2: radius round, scale multiply, longitude ----------------
    logic [56:0]             sum_gain;
    logic [24:0]             rq;
    logic [61:0]             sum_lon;
    logic [16:0]             a_lon;
    logic signed [18:0]      a_s, lon_w;
    logic signed [15:0]      lon_sat;
    logic [48:0]             y0_prod;
    logic                    r_l2_valid;
    logic signed [LAT_W-1:0] r_l2_y;
    logic [16:0]             r_l2_side;

    assign sum_gain = 57'(r_p_gain) + (57'd1 << 31);
    assign rq       = sum_gain[56:32];
    assign y0_prod  = 49'(r_view_scale) * 49'(rq);
    assign sum_lon  = 62'(r_p_lon) + (62'd1 << 44);
    assign a_lon    = sum_lon[61:45];
    assign a_s      = 19'(a_lon);

    always_comb begin
        if (r_l1_flags[F_XZ])
            lon_w = r_l1_flags[F_YN] ? -19'sd16384 : 19'sd16384;
        else if (r_l1_flags[F_YZ])
            lon_w = r_l1_flags[F_XN] ? -19'sd32768 : 19'sd0;
        else if (!r_l1_flags[F_XN])
            lon_w = r_l1_flags[F_YN] ? -a_s : a_s;
        else
            lon_w = r_l1_flags[F_YN] ? (a_s - 19'sd32768) : (19'sd32768 - a_s);

        if (lon_w > 19'sd32767)
            lon_sat = 16'sh7fff;
        else if (lon_w < -19'sd32768)
            lon_sat = -16'sh8000;
        else
            lon_sat = lon_w[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l2_valid <= 1'b0;
        end else begin
            r_l2_valid <= r_l1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l2_y    <= LAT_W'(y0_prod);
        r_l2_side <= {lon_sat, (y0_prod == '0)};
    end

    // ---------------- chain 2: latitude angle atan(scale * r) ----------------
    logic                    c2_v [0:NC];
    logic signed [LAT_W-1:0] c2_x [0:NC];
    logic signed [LAT_W-1:0] c2_y [0:NC];
    logic signed [ZW-1:0]    c2_z [0:NC];
    logic [16:0]             c2_s [0:NC];

    assign c2_v[0] = r_l2_valid;
    assign c2_x[0] = LAT_W'(1) <<< 36;
    assign c2_y[0] = r_l2_y;
    assign c2_z[0] = '0;
    assign c2_s[0] = r_l2_side;

    for (genvar g = 0; g < NC; g++) begin : g_c2
        stsc_cell #(.DW(LAT_W), .IDX(g), .SW(17)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c2_v[g]),
            .i_x     (c2_x[g]),
            .i_y     (c2_y[g]),
            .i_z     (c2_z[g]),
            .i_side  (c2_s[g]),
            .o_valid (c2_v[g+1]),
            .o_x     (c2_x[g+1]),
            .o_y     (c2_y[g+1]),
            .o_z     (c2_z[g+1]),
            .o_side  (c2_s[g+1])
        );
    end

    // ---------------- P3: latitude angle scale ----------------
    logic        r_p3_valid;
    logic [60:0] r_p_lat;
    logic [16:0] r_p3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else begin
            r_p3_valid <= c2_v[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_lat   <= 61'(stsc_clamp(c2_z[NC])) * 61'(TWO_OVER_PI_Q30);
        r_p3_side <= c2_s[NC];
    end

    // ---------------- output register ----------------
    logic [61:0]        sum_lat;
    logic signed [18:0] lat_w;
    logic signed [15:0] lat_sat;
    logic               r_done;
    logic signed [15:0] r_lon, r_lat;

    assign sum_lat = 62'(r_p_lat) + (62'd1 << 44);
    assign lat_w   = 19'sd16384 - 19'(sum_lat[61:45]);

    always_comb begin
        if (r_p3_side[0])
            lat_sat = 16'sd16384;
        else if (lat_w < -19'sd16384)
            lat_sat = -16'sd16384;
        else if (lat_w > 19'sd16384)
            lat_sat = 16'sd16384;
        else
            lat_sat = lat_w[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lon <= r_p3_side[16:1];
        r_lat <= lat_sat;
    end

    assign o_done           = r_done;
    assign o_longitude_norm = r_lon;
    assign o_latitude_norm  = r_lat;

    // ---------------- assertions ----------------
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("item did not come out after the pipeline latency");

    a_lat_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_latitude_norm <= 16'sd16384 && o_latitude_norm >= -16'sd16384))
        else $error("latitude out of range");

    // first edge out of reset: the strobe was cleared by the reset edge before it
    a_reset_quiet : assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_done)
        else $error("result strobe right after reset");

endmodule

FILE: verif/stsc_scoreboard.sv
// stsc_scoreboard: watches the point, result and APB channels of the projection block.
// It predicts each result with its own CORDIC model and compares them in order.
// Depends on stsc_pkg for SCALE_RESET and REG_VIEW_SCALE.
`timescale 1ns / 1ps

module stsc_scoreboard
    import stsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic signed [15:0] i_plane_x,
    input  logic signed [15:0] i_plane_y,
    input  logic               i_done,
    input  logic signed [15:0] i_longitude_norm,
    input  logic signed [15:0] i_latitude_norm,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);

    typedef struct packed {
        logic signed [15:0] lon;
        logic signed [15:0] lat;
    } sphere_coord_t;

    localparam int ROTATIONS = 16;

    sphere_coord_t expected_coords[$];
    logic [23:0]   scale_q;

    function automatic longint atan_entry(input int i);
        longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                            16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                            262143, 131071, 65535, 32767, 16383, 8191,
                            4095, 2047, 1023, 511, 255, 127};
        return tbl[i];
    endfunction

    // vectoring rotation toward the x axis; angle in Q30 rad
    function automatic longint vector_angle(input longint vx, input longint vy,
                                            output longint magnitude);
        longint sx, sy, ang;
        ang = 0;
        for (int i = 0; i < ROTATIONS; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
                vx = vx + sy; vy = vy - sx; ang += atan_entry(i);
            end else begin
                vx = vx - sy; vy = vy + sx; ang -= atan_entry(i);
            end
        end
        magnitude = vx;
        return ang;
    endfunction

    function automatic longint angle_q15(input longint ang, input logic [63:0] factor);
        logic [63:0] p;
        if (ang < 0) ang = 0;
        if (ang > 64'd1686629713) ang = 1686629713;
        p = (64'(ang) * factor + (64'd1 << 44)) >> 45;
        return longint'(p);
    endfunction

    function automatic sphere_coord_t project_point(input longint px, input longint py,
                                                    input logic [23:0] scale);
        sphere_coord_t r;
        longint ax, ay, mag, mag2, za, zl, a, lon, lat, rq, y0;
        logic [63:0] xs;
        ax = px < 0 ? -px : px;
        ay = py < 0 ? -py : py;
        za = vector_angle(ax <<< 16, ay <<< 16, mag);
        if (px == 0)
            lon = (py >= 0) ? 16384 : -16384;
        else if (py == 0)
            lon = (px > 0) ? 0 : -32768;
        else begin
            a = angle_q15(za, 64'd341782638);
            if (px > 0) lon = (py > 0) ? a : -a;
            else        lon = (py > 0) ? 32768 - a : a - 32768;
        end
        if (lon > 32767) lon = 32767;
        if (lon < -32768) lon = -32768;
        xs = 64'(mag) >> 8;
        rq = longint'((xs * 64'd652032874 + (64'd1 << 31)) >> 32);
        y0 = longint'({40'd0, scale}) * rq;
        if (y0 == 0)
            lat = 16384;
        else begin
            zl = vector_angle(64'sd1 <<< 36, y0, mag2);
            lat = 16384 - angle_q15(zl, 64'd683565276);
        end
        if (lat > 16384) lat = 16384;
        if (lat < -16384) lat = -16384;
        r.lon = lon[15:0];
        r.lat = lat[15:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        sphere_coord_t want;
        if (!i_rst_n) begin
            scale_q = SCALE_RESET;
            expected_coords.delete();
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_VIEW_SCALE)
                scale_q = i_pwdata[23:0];
            if (i_start && !i_busy)
                expected_coords.push_back(project_point(i_plane_x, i_plane_y, scale_q));
            if (i_done) begin
                o_results <= o_results + 1;
                if (expected_coords.size() == 0) begin
                    $display("%0t: unexpected result lon=%0d lat=%0d",
                             $time, i_longitude_norm, i_latitude_norm);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_coords.pop_front();
                    if (want.lon !== i_longitude_norm || want.lat !== i_latitude_norm) begin
                        $display("%0t: mismatch lon exp %0d got %0d, lat exp %0d got %0d",
                                 $time, want.lon, i_longitude_norm, want.lat,
                                 i_latitude_norm);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= expected_coords.size();
    end

endmodule

FILE: verif/tb_stereographic_to_sphere_coords.sv
// tb_stereographic_to_sphere_coords: stimulus and verdict for the projection block.
// Depends on stsc_pkg, the RTL top level and stsc_scoreboard.
`timescale 1ns / 1ps

module tb_stereographic_to_sphere_coords;
    import stsc_pkg::*;

    // extra drain margin, waited out after the last outstanding point has come back
    localparam int DRAIN_CYCLES = 60;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] plane_x = '0;
    logic signed [15:0] plane_y = '0;
    logic               done;
    logic signed [15:0] longitude_norm;
    logic signed [15:0] latitude_norm;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int errors, pending, results;

    always #5 i_clk = ~i_clk;

    stereographic_to_sphere_coords i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_plane_x(plane_x), .i_plane_y(plane_y), .o_done(done),
        .o_longitude_norm(longitude_norm), .o_latitude_norm(latitude_norm),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    stsc_scoreboard i_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_plane_x(plane_x), .i_plane_y(plane_y), .i_done(done),
        .i_longitude_norm(longitude_norm), .i_latitude_norm(latitude_norm),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // APB write: setup phase, then access until pready, then an idle phase before returning
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk iff pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending and wait out every outstanding point so the register can change safely
    task automatic drain_points();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one point; start stays high into the next item when no gap follows
    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input bit bursty);
        int roll, gap;
        start   <= 1'b1;
        plane_x <= x;
        plane_y <= y;
        @(posedge i_clk iff !busy);
        roll = $urandom_range(99);
        if (bursty || roll < 65) gap = 0;
        else if (roll < 95) gap = $urandom_range(3, 1);
        else gap = $urandom_range(40, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic random_points(input int count);
        logic [15:0] x, y;
        bit bursty;
        bursty = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) bursty = ($urandom_range(3) == 0);
            case ($urandom_range(3))
                0: begin x = 16'($urandom); y = 16'($urandom); end
                // small radius: latitude near the pole, fine angle steps
                1: begin x = 16'($signed($urandom_range(64)) - 32);
                         y = 16'($signed($urandom_range(64)) - 32); end
                // on an axis
                2: begin x = $urandom_range(1) ? 16'd0 : 16'($urandom);
                         y = (x == 0) ? 16'($urandom) : 16'd0; end
                default: begin x = 16'($urandom); y = 16'($urandom_range(255)) ^ x; end
            endcase
            send_point(x, y, bursty);
        end
    endtask

    task automatic directed_points();
        logic [15:0] pts[22][2] = '{
            '{16'd0, 16'd0}, '{16'd0, 16'd100}, '{16'd0, 16'hFF9C},
            '{16'd100, 16'd0}, '{16'hFF9C, 16'd0}, '{16'h7FFF, 16'h7FFF},
            '{16'h8000, 16'h8000}, '{16'h8000, 16'h7FFF}, '{16'h7FFF, 16'h8000},
            '{16'h8000, 16'd0}, '{16'd0, 16'h8000}, '{16'h7FFF, 16'd0},
            '{16'd0, 16'h7FFF}, '{16'hFFFF, 16'd1}, '{16'hFFFF, 16'hFFFF},
            '{16'd1, 16'hFFFF}, '{16'd1, 16'd1}, '{16'hC000, 16'd4000},
            '{16'hC000, 16'hF000}, '{16'd4000, 16'hC000}, '{16'h8000, 16'd1},
            '{16'd16384, 16'd16384}};
        foreach (pts[i]) send_point(pts[i][0], pts[i][1], 1'b0);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset scale (90 deg fov)
        directed_points();
        random_points(120);
        drain_points();

        // zero scale: latitude pinned at the pole; upper data bits must be dropped
        apb_write(3'd0, 32'hFF00_0000);
        directed_points();
        random_points(90);
        drain_points();

        // full-scale register: latitude saturates toward -0.5
        apb_write(3'd0, 32'h00FF_FFFF);
        directed_points();
        random_points(90);
        drain_points();

        // unity scale, then a write to an unmapped index that must not stick
        apb_write(3'd0, 32'h0001_0000);
        apb_write(3'd4, 32'h0000_0123);
        directed_points();
        random_points(120);
        drain_points();

        // random settings, mostly moderate, with garbage in the upper byte
        for (int k = 0; k < 3; k++) begin
            apb_write(3'd0, {8'($urandom),
                             (k == 0) ? 24'($urandom) : 24'($urandom_range(300000))});
            random_points(70);
            drain_points();
        end

        $display("Covered %0d results over reset, zero, unity, full-scale and random scales,",
                 results);
        $display("with axis, origin, quadrant and extreme points plus random gaps.");
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/stsc_pkg.sv
rtl/stsc_cell.sv
rtl/stereographic_to_sphere_coords.sv
verif/stsc_scoreboard.sv
verif/tb_stereographic_to_sphere_coords.sv
